// ===== sv/pending_reply_tracker_core_assert.svh =====
// assertion macros for the pending reply tracker
`ifndef PENDING_REPLY_TRACKER_CORE_ASSERT_SVH
`define PENDING_REPLY_TRACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define PRT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define PRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PRT_ASSERT(label, prop)
`define PRT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/prt_pkg.sv =====
// shared types, codes and helpers of the pending reply tracker
package prt_pkg;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_FIND   = 3'd1;
  localparam logic [2:0] CMD_UNLINK = 3'd2;
  localparam logic [2:0] CMD_MARK   = 3'd3;
  localparam logic [2:0] CMD_SCAN   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_NOTICE   = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;
  localparam logic [2:0] ST_INACTIVE = 3'd5;

  localparam logic [63:0] NO_DEADLINE = '1;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [63:0] name_id;
    logic        sync;
    logic [63:0] cookie;
    logic [63:0] deadline;
    logic        last;
  } prt_out_t;

  function automatic prt_out_t make_out(logic [2:0] status, logic [3:0] slot,
                                        logic [63:0] name_id, logic sync,
                                        logic [63:0] cookie, logic [63:0] deadline,
                                        logic last);
    prt_out_t o;
    o.status   = status;
    o.slot     = slot;
    o.name_id  = name_id;
    o.sync     = sync;
    o.cookie   = cookie;
    o.deadline = deadline;
    o.last     = last;
    return o;
  endfunction

endpackage

// ===== sv/pending_reply_tracker_core.sv =====
// pending reply tracker: outstanding request table with timeout scan
// Holds up to TABLE_ENTRIES outstanding requests. An age-ordered list of slot
// numbers (newest first) is kept in a shift line, and a small sequencer walks it
// entry by entry (table read, then compare) through one shared compare unit.
// Insert searches the lowest free slot one slot a cycle. Find, unlink and mark
// walk the entries from the newest until the first match, then give the result.
// A scan walks every live entry and puts out each timeout notice, which waits
// in the output register until taken, before the final result. Each result
// waits in an output register until its transfer; the block takes no new item
// while one is at work.
`include "pending_reply_tracker_core_assert.svh"
module pending_reply_tracker_core import prt_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int SOURCE_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [63:0] request_cookie_i,
  input  logic [15:0] source_id_i,
  input  logic        any_source_i,
  input  logic [63:0] bus_name_id_i,
  input  logic [63:0] expiry_time_i,
  input  logic        sync_flag_i,
  input  logic [63:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  found_slot_o,
  output logic [63:0] found_name_id_o,
  output logic        found_sync_o,
  output logic [63:0] notice_cookie_o,
  output logic [63:0] next_deadline_o,
  output logic        last_result_o
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int SRC_W = (SOURCE_BITS < 16) ? SOURCE_BITS : 16;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]       state_q;
  logic             active_q;
  logic             cont_q;     // after the transfer, resume the walk
  logic [CNT_W-1:0] cnt_q;      // live entries
  logic [CNT_W-1:0] rank_q;     // walk position in the age list
  logic [IDX_W-1:0] ins_idx_q;  // free slot search
  logic [IDX_W-1:0] slot_q;     // slot under evaluation
  logic [63:0]      dl_q;       // running earliest deadline
  prt_out_t         out_q;

  // item captured at accept
  logic [2:0]       cmd_q;
  logic [63:0]      cookie_q;
  logic [SRC_W-1:0] src_q;
  logic             any_q;
  logic [63:0]      name_q;
  logic [63:0]      exp_q;
  logic             sync_in_q;
  logic [63:0]      now_q;

  // per slot flags and age list
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [TABLE_ENTRIES-1:0] sync_q;
  logic [TABLE_ENTRIES-1:0] intr_q;
  logic [IDX_W-1:0]         order_q [TABLE_ENTRIES];

  // table payload memories
  logic [63:0]      cookie_mem [TABLE_ENTRIES];
  logic [SRC_W-1:0] src_mem    [TABLE_ENTRIES];
  logic [63:0]      name_mem   [TABLE_ENTRIES];
  logic [63:0]      dl_mem     [TABLE_ENTRIES];
  logic [63:0]      rd_cookie_q;
  logic [SRC_W-1:0] rd_src_q;
  logic [63:0]      rd_name_q;
  logic [63:0]      rd_dl_q;

  logic [IDX_W-1:0] rank_idx;
  logic             ins_free;
  logic             hit;
  logic             ev_sync;
  logic             ev_intr;
  logic             ev_skip;
  logic             ev_live;
  logic             ev_notice;
  logic             do_remove;
  logic             do_insert;

  assign rank_idx  = rank_q[IDX_W-1:0];
  assign ins_free  = !valid_q[ins_idx_q];
  assign ev_sync   = sync_q[slot_q];
  assign ev_intr   = intr_q[slot_q];
  // entry compare for find, unlink and mark
  assign hit       = (rd_cookie_q == cookie_q) && (any_q || (rd_src_q == src_q));
  // scan classification
  assign ev_skip   = ev_sync && !ev_intr;
  assign ev_live   = rd_dl_q > now_q;
  assign ev_notice = (rd_dl_q != 64'd0) && !ev_intr;
  assign do_insert = (state_q == S_INS) && ins_free;
  assign do_remove = (state_q == S_EV) &&
                     (((cmd_q == CMD_SCAN) && !ev_skip && !ev_live) ||
                      ((cmd_q == CMD_UNLINK) && hit));

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = (state_q == S_OUT);
  assign status_o        = out_q.status;
  assign found_slot_o    = out_q.slot;
  assign found_name_id_o = out_q.name_id;
  assign found_sync_o    = out_q.sync;
  assign notice_cookie_o = out_q.cookie;
  assign next_deadline_o = out_q.deadline;
  assign last_result_o   = out_q.last;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      active_q  <= 1'b1;
      cont_q    <= 1'b0;
      cnt_q     <= '0;
      rank_q    <= '0;
      ins_idx_q <= '0;
      slot_q    <= '0;
      dl_q      <= NO_DEADLINE;
      out_q     <= '0;
      valid_q   <= '0;
      cmd_q     <= CMD_INSERT;
      cookie_q  <= '0;
      src_q     <= '0;
      any_q     <= 1'b0;
      name_q    <= '0;
      exp_q     <= '0;
      sync_in_q <= 1'b0;
      now_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q     <= command_i;
            cookie_q  <= request_cookie_i;
            src_q     <= source_id_i[SRC_W-1:0];
            any_q     <= any_source_i;
            name_q    <= bus_name_id_i;
            exp_q     <= expiry_time_i;
            sync_in_q <= sync_flag_i;
            now_q     <= now_time_i;
            rank_q    <= '0;
            ins_idx_q <= '0;
            dl_q      <= NO_DEADLINE;
            cont_q    <= 1'b0;
            case (command_i)
              CMD_INSERT: begin
                if (cnt_q == FULL_CNT) begin
                  out_q   <= make_out(ST_FULL, 4'd0, 64'd0, 1'b0, 64'd0, 64'd0, 1'b1);
                  state_q <= S_OUT;
                end else begin
                  state_q <= S_INS;
                end
              end
              CMD_FIND, CMD_UNLINK, CMD_MARK: begin
                state_q <= S_RD;
              end
              CMD_SCAN: begin
                if (!active_q) begin
                  out_q   <= make_out(ST_INACTIVE, 4'd0, 64'd0, 1'b0, 64'd0, 64'd0,
                                      1'b1);
                  state_q <= S_OUT;
                end else begin
                  state_q <= S_RD;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_INS: begin
          if (ins_free) begin
            valid_q[ins_idx_q] <= 1'b1;
            cnt_q   <= cnt_q + 1'b1;
            out_q   <= make_out(ST_OK, 4'(ins_idx_q), name_q, sync_in_q, 64'd0, 64'd0,
                                1'b1);
            state_q <= S_OUT;
          end else begin
            ins_idx_q <= ins_idx_q + 1'b1;
          end
        end
        S_RD: begin
          if (rank_q == cnt_q) begin
            if (cmd_q == CMD_SCAN) begin
              out_q <= make_out(ST_DONE, 4'd0, 64'd0, 1'b0, 64'd0, dl_q, 1'b1);
            end else begin
              out_q <= make_out(ST_NOTFOUND, 4'd0, 64'd0, 1'b0, 64'd0, 64'd0, 1'b1);
            end
            cont_q  <= 1'b0;
            state_q <= S_OUT;
          end else begin
            slot_q  <= order_q[rank_idx];
            state_q <= S_EV;
          end
        end
        S_EV: begin
          if (cmd_q == CMD_SCAN) begin
            state_q <= S_RD;
            if (ev_skip) begin
              rank_q <= rank_q + 1'b1;
            end else if (ev_live) begin
              if (rd_dl_q < dl_q) begin
                dl_q <= rd_dl_q;
              end
              rank_q <= rank_q + 1'b1;
            end else begin
              // expired: removed, rank stays as older entries move up
              valid_q[slot_q] <= 1'b0;
              cnt_q <= cnt_q - 1'b1;
              if (ev_notice) begin
                out_q   <= make_out(ST_NOTICE, 4'(slot_q), rd_name_q, ev_sync,
                                    rd_cookie_q, 64'd0, 1'b0);
                cont_q  <= 1'b1;
                state_q <= S_OUT;
              end
            end
          end else if (hit) begin
            out_q   <= make_out(ST_OK, 4'(slot_q), rd_name_q, ev_sync, 64'd0, 64'd0,
                                1'b1);
            cont_q  <= 1'b0;
            state_q <= S_OUT;
            if (cmd_q == CMD_UNLINK) begin
              valid_q[slot_q] <= 1'b0;
              cnt_q <= cnt_q - 1'b1;
            end
          end else begin
            rank_q  <= rank_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            state_q <= cont_q ? S_RD : S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // age list: newest at the head, removal closes the gap
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      order_q[0] <= ins_idx_q;
      for (int j = 1; j < TABLE_ENTRIES; j++) begin
        order_q[j] <= order_q[j-1];
      end
    end else if (do_remove) begin
      for (int j = 0; j < TABLE_ENTRIES - 1; j++) begin
        if (CNT_W'(j) >= rank_q) begin
          order_q[j] <= order_q[j+1];
        end
      end
    end
  end

  // slot flags
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      sync_q[ins_idx_q] <= sync_in_q;
      intr_q[ins_idx_q] <= 1'b0;
    end else if ((state_q == S_EV) && (cmd_q == CMD_MARK) && hit) begin
      intr_q[slot_q] <= 1'b1;
    end
  end

  // payload memories, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      cookie_mem[ins_idx_q] <= cookie_q;
      src_mem[ins_idx_q]    <= src_q;
      name_mem[ins_idx_q]   <= name_q;
      dl_mem[ins_idx_q]     <= exp_q;
    end
    if ((state_q == S_RD) && (rank_q != cnt_q)) begin
      rd_cookie_q <= cookie_mem[order_q[rank_idx]];
      rd_src_q    <= src_mem[order_q[rank_idx]];
      rd_name_q   <= name_mem[order_q[rank_idx]];
      rd_dl_q     <= dl_mem[order_q[rank_idx]];
    end
  end

  `PRT_ASSERT(a_cnt_range, cnt_q <= FULL_CNT)
  `PRT_ASSERT(a_cnt_matches_valid, $countones(valid_q) == 32'(cnt_q))
  `PRT_ASSERT(a_walk_in_range, (state_q != S_EV) || (rank_q < cnt_q))
  `PRT_ASSERT_NEXT(a_insert_fills, do_insert, valid_q != '0)

endmodule

// ===== dv/tb_pending_reply_tracker_core.sv =====
// self-checking testbench of the pending reply tracker core
`timescale 1ns / 1ps

// expected results of the request table, built from a behavioral copy of it
class reply_table_scoreboard;
  localparam int ENTRIES = 16;

  bit          active;
  bit          live[ENTRIES];
  logic [63:0] cookie_q[ENTRIES];
  logic [15:0] source_q[ENTRIES];
  logic [63:0] name_q[ENTRIES];
  logic [63:0] deadline_q[ENTRIES];
  bit          sync_q[ENTRIES];
  bit          intr_q[ENTRIES];
  int unsigned age_q[ENTRIES];
  prt_pkg::prt_out_t pending_results[$];
  int errors;

  function new();
    active = 1;
    errors = 0;
    foreach (live[i]) live[i] = 0;
  endfunction

  function int live_count();
    int n;
    n = 0;
    foreach (live[i]) if (live[i]) n++;
    return n;
  endfunction

  // newest entry with matching cookie (and source unless any)
  function int newest_match(logic [63:0] ck, logic [15:0] src, bit any);
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!live[i] || cookie_q[i] != ck) continue;
      if (!any && source_q[i] != src) continue;
      if (best < 0 || age_q[i] < age_q[best]) best = i;
    end
    return best;
  endfunction

  function void drop_entry(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (live[i] && i != s && age_q[i] > age_q[s]) age_q[i]--;
    live[s] = 0;
  endfunction

  function void push(logic [2:0] st, logic [3:0] slot, logic [63:0] nm, bit sy,
                     logic [63:0] ck, logic [63:0] dl, bit last);
    pending_results.push_back(prt_pkg::make_out(st, slot, nm, sy, ck, dl, last));
  endfunction

  // note one accepted input transfer
  function void note_request(logic [2:0] cmd, logic [63:0] ck, logic [15:0] src,
                             bit any, logic [63:0] nm, logic [63:0] expiry, bit sy,
                             logic [63:0] now);
    int s, cnt;
    int unsigned rank;
    logic [63:0] earliest;
    case (cmd)
      prt_pkg::CMD_INSERT: begin
        s = -1;
        for (int i = 0; i < ENTRIES; i++) if (!live[i]) begin s = i; break; end
        if (s < 0) begin
          push(prt_pkg::ST_FULL, 0, 0, 0, 0, 0, 1);
        end else begin
          for (int i = 0; i < ENTRIES; i++) if (live[i]) age_q[i]++;
          live[s] = 1; cookie_q[s] = ck; source_q[s] = src; name_q[s] = nm;
          deadline_q[s] = expiry; sync_q[s] = sy; intr_q[s] = 0; age_q[s] = 0;
          push(prt_pkg::ST_OK, s[3:0], nm, sy, 0, 0, 1);
        end
      end
      prt_pkg::CMD_FIND, prt_pkg::CMD_UNLINK, prt_pkg::CMD_MARK: begin
        s = newest_match(ck, src, any);
        if (s < 0) begin
          push(prt_pkg::ST_NOTFOUND, 0, 0, 0, 0, 0, 1);
        end else begin
          push(prt_pkg::ST_OK, s[3:0], name_q[s], sync_q[s], 0, 0, 1);
          if (cmd == prt_pkg::CMD_UNLINK) drop_entry(s);
          else if (cmd == prt_pkg::CMD_MARK) intr_q[s] = 1;
        end
      end
      prt_pkg::CMD_SCAN: begin
        if (!active) begin
          push(prt_pkg::ST_INACTIVE, 0, 0, 0, 0, 0, 1);
        end else begin
          earliest = prt_pkg::NO_DEADLINE;
          cnt = live_count();
          rank = 0;
          while (cnt > 0) begin
            s = -1;
            for (int i = 0; i < ENTRIES; i++)
              if (live[i] && age_q[i] == rank) begin s = i; break; end
            cnt--;
            if (s < 0) begin rank++; continue; end
            if (sync_q[s] && !intr_q[s]) begin rank++; continue; end
            if (deadline_q[s] > now) begin
              if (earliest > deadline_q[s]) earliest = deadline_q[s];
              rank++;
              continue;
            end
            if (deadline_q[s] != 0 && !intr_q[s])
              push(prt_pkg::ST_NOTICE, s[3:0], name_q[s], sync_q[s], cookie_q[s], 0, 0);
            drop_entry(s);
          end
          push(prt_pkg::ST_DONE, 0, 0, 0, 0, earliest, 1);
        end
      end
      default: ;
    endcase
  endfunction

  // compare one output transfer with the oldest expectation
  function void check_result(prt_pkg::prt_out_t got);
    prt_pkg::prt_out_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result, status %0d", got.status);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status); errors++;
    end
    if (got.slot !== want.slot) begin
      $error("found_slot: expected %0d, actual %0d", want.slot, got.slot); errors++;
    end
    if (got.name_id !== want.name_id) begin
      $error("found_name_id: expected %h, actual %h", want.name_id, got.name_id); errors++;
    end
    if (got.sync !== want.sync) begin
      $error("found_sync: expected %0d, actual %0d", want.sync, got.sync); errors++;
    end
    if (got.cookie !== want.cookie) begin
      $error("notice_cookie: expected %h, actual %h", want.cookie, got.cookie); errors++;
    end
    if (got.deadline !== want.deadline) begin
      $error("next_deadline: expected %h, actual %h", want.deadline, got.deadline);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last_result: expected %0d, actual %0d", want.last, got.last); errors++;
    end
  endfunction
endclass

module tb_pending_reply_tracker_core;
  import prt_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_wdata_i = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [63:0] request_cookie_i = '0;
  logic [15:0] source_id_i = '0;
  logic        any_source_i = 0;
  logic [63:0] bus_name_id_i = '0;
  logic [63:0] expiry_time_i = '0;
  logic        sync_flag_i = 0;
  logic [63:0] now_time_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [2:0]  status_o;
  logic [3:0]  found_slot_o;
  logic [63:0] found_name_id_o;
  logic        found_sync_o;
  logic [63:0] notice_cookie_o;
  logic [63:0] next_deadline_o;
  logic        last_result_o;

  reply_table_scoreboard table_model = new();

  // small pools so that finds and scans actually hit stored entries
  logic [63:0] cookie_pool[4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                                  64'h1234_5678_9abc_def0, 64'h8000_0000_0000_0001};
  logic [15:0] source_pool[3] = '{16'h0000, 16'hFFFF, 16'h5a5a};

  bit hold_sink;         // long receiver hold-off while set
  bit stimulus_done;

  pending_reply_tracker_core dut (.*);

  always #5 clk_i = ~clk_i;

  // input monitor: feed each accepted transfer to the model
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      table_model.note_request(command_i, request_cookie_i, source_id_i, any_source_i,
                               bus_name_id_i, expiry_time_i, sync_flag_i, now_time_i);
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      table_model.check_result(make_out(status_o, found_slot_o, found_name_id_o,
                                        found_sync_o, notice_cookie_o,
                                        next_deadline_o, last_result_o));
  end

  // receiver: random stall per result, none in some stretches, long hold on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        out_stall_i <= 1;
        repeat (400) @(posedge clk_i);
        hold_sink = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_stall_i <= 1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 0;
      @(posedge clk_i);
      while (!out_valid_o || out_stall_i) @(posedge clk_i);
    end
  end

  // offer one transfer and wait for it to be taken
  task automatic send_request(logic [2:0] cmd, logic [63:0] ck, logic [15:0] src,
                              bit any, logic [63:0] nm, logic [63:0] expiry, bit sy,
                              logic [63:0] now, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    command_i <= cmd;
    request_cookie_i <= ck;
    source_id_i <= src;
    any_source_i <= any;
    bus_name_id_i <= nm;
    expiry_time_i <= expiry;
    sync_flag_i <= sy;
    now_time_i <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (table_model.pending_results.size() != 0) @(posedge clk_i);
    // unknown commands give no result; the block drops them while idle
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_active(bit val);
    cfg_we_i <= 1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    table_model.active = val;
  endtask

  // mostly well-formed traffic: inserts from the pools, matches against them,
  // scans with times near the stored deadlines; some wide random noise
  task automatic random_request(bit no_gap = 0);
    logic [2:0]  cmd;
    logic [63:0] ck, now, expiry;
    logic [15:0] src;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) cmd = CMD_INSERT;
    else if (pick < 50) cmd = CMD_FIND;
    else if (pick < 65) cmd = CMD_UNLINK;
    else if (pick < 78) cmd = CMD_MARK;
    else if (pick < 97) cmd = CMD_SCAN;
    else cmd = 3'($urandom_range(5, 7));
    ck = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                     : cookie_pool[$urandom_range(0, 3)];
    src = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                      : source_pool[$urandom_range(0, 2)];
    case ($urandom_range(0, 5))
      0: expiry = 64'h0;
      1: expiry = '1;
      2: expiry = {$urandom, $urandom};
      default: expiry = 64'($urandom_range(1, 2000));
    endcase
    now = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                      : 64'($urandom_range(0, 2000));
    send_request(cmd, ck, src, 1'($urandom_range(0, 1)), {$urandom, $urandom}, expiry,
                 $urandom_range(0, 3) == 0, now, no_gap);
  endtask

  initial begin
    hold_sink = 0;
    stimulus_done = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, every command, special cases
    write_active(1);
    send_request(CMD_SCAN, 0, 0, 0, 0, 0, 0, 64'd100);            // empty table
    send_request(CMD_FIND, '1, '1, 0, 0, 0, 0, 0);                // not found
    send_request(CMD_INSERT, '1, '1, 0, '1, '1, 1, 0);            // sync, never expires
    send_request(CMD_INSERT, 0, 0, 0, 0, 0, 0, 0);                // zero deadline
    send_request(CMD_INSERT, 64'h55, 16'h1, 0, 64'hA, 64'd50, 0, 0);
    send_request(CMD_INSERT, 64'h55, 16'h2, 0, 64'hB, 64'd60, 1, 0); // same cookie, newer
    send_request(CMD_FIND, 64'h55, 16'h1, 0, 0, 0, 0, 0);         // source match
    send_request(CMD_FIND, 64'h55, 16'h7, 1, 0, 0, 0, 0);         // any source, newest
    send_request(CMD_MARK, 64'h55, 16'h2, 0, 0, 0, 0, 0);         // interrupt sync entry
    send_request(CMD_UNLINK, 64'h55, 16'h1, 0, 0, 0, 0, 0);
    send_request(CMD_UNLINK, 64'h55, 16'h1, 0, 0, 0, 0, 0);       // already gone
    send_request(3'd5, 0, 0, 0, 0, 0, 0, 0);                      // ignored commands
    send_request(3'd7, '1, '1, 1, '1, '1, 1, '1);
    send_request(CMD_SCAN, 0, 0, 0, 0, 0, 0, 64'd100);
    drain_results();
    write_active(0);
    send_request(CMD_SCAN, 0, 0, 0, 0, 0, 0, '1);                 // inactive
    drain_results();
    write_active(1);
    for (int i = 0; i < 17; i++)                                  // fill past full
      send_request(CMD_INSERT, 64'(i), 16'(i), 0, 64'(i), 64'(i * 3 + 1), i[0], 0);
    send_request(CMD_SCAN, 0, 0, 0, 0, 0, 0, '1);                 // expire all but the sync entries
    drain_results();

    // random phases with register changes between them
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 2) begin
        hold_sink = 1;                                            // sink blocks for long
        for (int k = 0; k < 30; k++) random_request(1);
      end
      for (int k = 0; k < 95; k++) random_request(phase == 3 && k < 30);
      drain_results();                                            // sender pauses
      write_active(phase != 1 ? 1'($urandom_range(0, 1)) : 1'b0);
      @(posedge clk_i);
      write_active(phase == 0 ? 1'b0 : 1'b1);
    end

    in_valid_i <= 0;
    @(posedge clk_i);
    while (table_model.pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (table_model.errors == 0) $display("pending_reply_tracker_core regression: pass");
    else $display("pending_reply_tracker_core regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("pending_reply_tracker_core regression: fail");
    $finish;
  end
endmodule
